/* rtl/instrument_link_block_framer_assert.svh */
// assertion macros for the instrument link block framer
`ifndef INSTRUMENT_LINK_BLOCK_FRAMER_ASSERT_SVH
`define INSTRUMENT_LINK_BLOCK_FRAMER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ILBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ILBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ilbf_pkg.sv */
// shared types and constants for the instrument link block framer
`default_nettype none

package ilbf_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_W        = 8 * HEADER_BYTES;
    localparam int BEAT_CNT_W   = $clog2(HEADER_BYTES);
    localparam int CFG_IDX_W    = 1;

    localparam logic [BEAT_CNT_W-1:0] LAST_BEAT = BEAT_CNT_W'(HEADER_BYTES - 1);

    localparam logic [7:0] FLAG_DATA    = 8'h80;
    localparam logic [7:0] FLAG_REMOTE  = 8'h40;
    localparam logic [7:0] FLAG_CLEAR   = 8'h10;
    localparam logic [7:0] FLAG_SRQ     = 8'h08;
    localparam logic [7:0] FLAG_POLL    = 8'h04;
    localparam logic [7:0] FLAG_EOI     = 8'h01;
    localparam logic [7:0] LINK_VERSION = 8'h01;
    localparam logic [7:0] SRQ_ON_CHAR  = 8'h31;
    localparam logic [7:0] SEQ_MAX      = 8'hFF;
    localparam logic [7:0] SEQ_FIRST    = 8'h01;

    localparam logic CMD_TX = 1'b0;
    localparam logic CMD_RX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_REMOTE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_STALE = 1'd1;

    typedef enum logic [1:0] {
        KIND_HDR   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    // one step's result: a full header or a single receive result
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [HDR_W-1:0] data;
        logic             eom;
        logic             srq;
        logic             num;
    } t_res;

endpackage

`default_nettype wire

/* rtl/instrument_link_block_framer.sv */
// top level: link block framer core with serializing result register
//
// channel  direction  handshake                  payload
// in       request in  i_in_valid / o_in_ready   command, rx_byte, tx_length, tx flags
// out      result out  o_out_valid / i_out_ready kind, byte, last, eom, srq, numbering
// cfg      write in    i_cfg_we                  i_cfg_index, i_cfg_data
//
// a receive request gives at most one result, registered and shown in the cycle after it is taken
// a transmit request gives eight header beats from a shift register
// the result register frees on its last beat, so a new request enters that cycle
// i_out_ready low holds the result register; o_in_ready drops while it is busy
// reset is synchronous, active low, and clears all link state
`default_nettype none

`include "instrument_link_block_framer_assert.svh"

module instrument_link_block_framer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_command,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic [31:0]                    i_tx_length,
    input  wire logic                           i_tx_eoi,
    input  wire logic                           i_tx_clear,
    input  wire logic                           i_tx_poll,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_out_kind,
    output logic [7:0]                          o_out_byte,
    output logic                                o_last_of_run,
    output logic                                o_end_of_message,
    output logic                                o_srq_asserted,
    output logic                                o_numbering_seen,
    input  wire logic                           i_cfg_we,
    input  wire logic [ilbf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                           i_cfg_data
);

    logic                                r_valid;
    logic [ilbf_pkg::HDR_W-1:0]          r_sh;
    logic [ilbf_pkg::BEAT_CNT_W-1:0]     r_cnt;
    ilbf_pkg::t_kind                     r_kind;
    logic                                r_eom;
    logic                                r_srq;
    logic                                r_num;

    logic           accept;
    logic           beat;
    logic           last_beat;
    ilbf_pkg::t_res res;

    assign last_beat  = r_cnt == '0;
    assign beat       = r_valid && i_out_ready;
    assign o_in_ready = !r_valid || (i_out_ready && last_beat);
    assign accept     = i_in_valid && o_in_ready;

    ilbf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_rx_byte   (i_rx_byte),
        .i_tx_length (i_tx_length),
        .i_tx_eoi    (i_tx_eoi),
        .i_tx_clear  (i_tx_clear),
        .i_tx_poll   (i_tx_poll),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (res.valid) begin
                r_valid <= 1'b1;
                r_sh    <= res.data;
                r_cnt   <= (res.kind == ilbf_pkg::KIND_HDR) ? ilbf_pkg::LAST_BEAT : '0;
                r_kind  <= res.kind;
                r_eom   <= res.eom;
                r_srq   <= res.srq;
                r_num   <= res.num;
            end else if (beat && last_beat) begin
                r_valid <= 1'b0;
            end else if (beat) begin
                // next header byte moves to the top
                r_sh  <= {r_sh[ilbf_pkg::HDR_W-9:0], 8'h00};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_out_valid      = r_valid;
    assign o_out_kind       = r_kind;
    assign o_out_byte       = r_sh[ilbf_pkg::HDR_W-1 -: 8];
    assign o_last_of_run    = last_beat;
    assign o_end_of_message = r_eom;
    assign o_srq_asserted   = r_srq;
    assign o_numbering_seen = r_num;

    `ILBF_ASSERT_NOW(a_busy_blocks_in, i_clk, i_rst_n,
        r_valid && !last_beat, !o_in_ready, "request taken mid header")
    `ILBF_ASSERT_NOW(a_single_non_hdr, i_clk, i_rst_n,
        r_valid && (r_kind != ilbf_pkg::KIND_HDR), last_beat, "receive result spans beats")
    `ILBF_ASSERT_NEXT(a_beat_advance, i_clk, i_rst_n,
        beat && !last_beat,
        r_valid && (r_cnt == $past(r_cnt) - 1'b1), "header beat count slipped")
    `ILBF_ASSERT_NEXT(a_hdr_load, i_clk, i_rst_n,
        accept && (i_command == ilbf_pkg::CMD_TX),
        r_valid && (r_cnt == ilbf_pkg::LAST_BEAT), "transmit request gave no header")

endmodule

`default_nettype wire

/* rtl/ilbf_core.sv */
// framing and deframing state with per-request next-state logic
`default_nettype none

module ilbf_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_command,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic [31:0]                    i_tx_length,
    input  wire logic                           i_tx_eoi,
    input  wire logic                           i_tx_clear,
    input  wire logic                           i_tx_poll,
    input  wire logic                           i_cfg_we,
    input  wire logic [ilbf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                           i_cfg_data,
    output ilbf_pkg::t_res                      o_res
);

    logic       r_remote_mode, r_flush_stale;
    logic       r_in_payload, n_in_payload;
    logic [2:0] r_header_count, n_header_count;
    logic [7:0] r_header_flags, n_header_flags;
    logic [7:0] r_header_version, n_header_version;
    logic [7:0] r_header_seq, n_header_seq;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic       r_block_eoi, n_block_eoi;
    logic       r_block_srq, n_block_srq;
    logic       r_block_stale, n_block_stale;
    logic       r_srq_first_seen, n_srq_first_seen;
    logic       r_srq_status, n_srq_status;
    logic [7:0] r_next_seq, n_next_seq;
    logic [7:0] r_last_sent_seq, n_last_sent_seq;
    logic       r_seq_numbering, n_seq_numbering;

    logic [7:0]  tx_flags;
    logic [31:0] len_full;
    logic [31:0] len_dec;
    logic        hdr_bad;
    logic        hdr_stale;
    ilbf_pkg::t_res res;

    assign tx_flags = ilbf_pkg::FLAG_DATA
                    | (i_tx_eoi      ? ilbf_pkg::FLAG_EOI    : 8'h00)
                    | (r_remote_mode ? ilbf_pkg::FLAG_REMOTE : 8'h00)
                    | (i_tx_clear    ? ilbf_pkg::FLAG_CLEAR  : 8'h00)
                    | (i_tx_poll     ? ilbf_pkg::FLAG_POLL   : 8'h00);

    assign len_full  = {r_bytes_left[23:0], i_rx_byte};
    assign len_dec   = r_bytes_left - 32'd1;
    assign hdr_bad   = ((r_header_flags & ilbf_pkg::FLAG_DATA) == 8'h00)
                    || (r_header_version != ilbf_pkg::LINK_VERSION);
    assign hdr_stale = r_flush_stale && (r_header_seq != 8'h00)
                    && (r_last_sent_seq > r_header_seq);

    always_comb begin
        n_in_payload     = r_in_payload;
        n_header_count   = r_header_count;
        n_header_flags   = r_header_flags;
        n_header_version = r_header_version;
        n_header_seq     = r_header_seq;
        n_bytes_left     = r_bytes_left;
        n_block_eoi      = r_block_eoi;
        n_block_srq      = r_block_srq;
        n_block_stale    = r_block_stale;
        n_srq_first_seen = r_srq_first_seen;
        n_srq_status     = r_srq_status;
        n_next_seq       = r_next_seq;
        n_last_sent_seq  = r_last_sent_seq;
        n_seq_numbering  = r_seq_numbering;
        res              = '0;
        res.kind         = ilbf_pkg::KIND_HDR;

        if (i_accept) begin
            if (i_command == ilbf_pkg::CMD_TX) begin
                if (r_flush_stale && r_in_payload) begin
                    n_block_stale = 1'b1;
                end
                n_last_sent_seq = r_next_seq;
                if (i_tx_eoi) begin
                    n_next_seq = (r_next_seq == ilbf_pkg::SEQ_MAX) ? ilbf_pkg::SEQ_FIRST
                                                                  : r_next_seq + 8'd1;
                end
                res.valid = 1'b1;
                res.kind  = ilbf_pkg::KIND_HDR;
                res.data  = {tx_flags, ilbf_pkg::LINK_VERSION, r_next_seq, 8'h00,
                             i_tx_length};
            end else if (!r_in_payload) begin
                case (r_header_count)
                    3'd0: begin
                        n_header_flags = i_rx_byte;
                        n_bytes_left   = 32'd0;
                    end
                    3'd1: n_header_version = i_rx_byte;
                    3'd2: n_header_seq     = i_rx_byte;
                    3'd3: ; // reserved byte is ignored
                    default: n_bytes_left = len_full;
                endcase
                n_header_count = r_header_count + 3'd1;
                if (r_header_count == 3'd7) begin
                    n_header_count = 3'd0;
                    if (hdr_bad) begin
                        n_seq_numbering  = 1'b0;
                        n_srq_first_seen = 1'b0;
                        n_block_stale    = 1'b0;
                        res.valid        = 1'b1;
                        res.kind         = ilbf_pkg::KIND_BAD;
                    end else begin
                        n_block_eoi      = (r_header_flags & ilbf_pkg::FLAG_EOI) != 8'h00;
                        n_block_srq      = (r_header_flags & ilbf_pkg::FLAG_SRQ) != 8'h00;
                        n_seq_numbering  = r_header_seq != 8'h00;
                        n_block_stale    = hdr_stale;
                        n_srq_first_seen = 1'b0;
                        if (len_full != 32'd0) begin
                            n_in_payload = 1'b1;
                        end else begin
                            // empty block ends at once
                            n_block_stale = 1'b0;
                            if (!hdr_stale && n_block_srq) begin
                                n_srq_status = 1'b0;
                            end else if (!hdr_stale && n_block_eoi) begin
                                res.valid = 1'b1;
                                res.kind  = ilbf_pkg::KIND_EMPTY;
                                res.eom   = 1'b1;
                            end
                        end
                    end
                end
            end else begin
                n_bytes_left = len_dec;
                if (r_block_stale) begin
                    // stale block is dropped
                end else if (r_block_srq) begin
                    if (!r_srq_first_seen) begin
                        n_srq_status     = i_rx_byte == ilbf_pkg::SRQ_ON_CHAR;
                        n_srq_first_seen = 1'b1;
                    end
                end else begin
                    res.valid = 1'b1;
                    res.kind  = ilbf_pkg::KIND_DATA;
                    res.data[ilbf_pkg::HDR_W-1 -: 8] = i_rx_byte;
                    res.eom   = r_block_eoi && (len_dec == 32'd0);
                end
                if (len_dec == 32'd0) begin
                    n_in_payload     = 1'b0;
                    n_header_count   = 3'd0;
                    n_srq_first_seen = 1'b0;
                    n_block_stale    = 1'b0;
                end
            end
        end
        res.srq = n_srq_status;
        res.num = n_seq_numbering;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote_mode    <= 1'b0;
            r_flush_stale    <= 1'b0;
            r_in_payload     <= 1'b0;
            r_header_count   <= 3'd0;
            r_header_flags   <= 8'h00;
            r_header_version <= 8'h00;
            r_header_seq     <= 8'h00;
            r_bytes_left     <= 32'd0;
            r_block_eoi      <= 1'b0;
            r_block_srq      <= 1'b0;
            r_block_stale    <= 1'b0;
            r_srq_first_seen <= 1'b0;
            r_srq_status     <= 1'b0;
            r_next_seq       <= ilbf_pkg::SEQ_FIRST;
            r_last_sent_seq  <= 8'h00;
            r_seq_numbering  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == ilbf_pkg::REG_REMOTE_MODE)) begin
                r_remote_mode <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == ilbf_pkg::REG_FLUSH_STALE)) begin
                r_flush_stale <= i_cfg_data;
            end
            r_in_payload     <= n_in_payload;
            r_header_count   <= n_header_count;
            r_header_flags   <= n_header_flags;
            r_header_version <= n_header_version;
            r_header_seq     <= n_header_seq;
            r_bytes_left     <= n_bytes_left;
            r_block_eoi      <= n_block_eoi;
            r_block_srq      <= n_block_srq;
            r_block_stale    <= n_block_stale;
            r_srq_first_seen <= n_srq_first_seen;
            r_srq_status     <= n_srq_status;
            r_next_seq       <= n_next_seq;
            r_last_sent_seq  <= n_last_sent_seq;
            r_seq_numbering  <= n_seq_numbering;
        end
    end

endmodule

`default_nettype wire
